// ===== rtl/i2c_fts_pkg.sv =====
// Shared types and constants for the I2C framed transfer sequencer.
// No dependencies; imported by every module of the block.

package i2c_fts_pkg;

   localparam int TX_DEPTH = 64;
   localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int SEND_W   = $clog2(TX_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_EVENT = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_ADDR   = 4'd1,
      PH_SLEN   = 4'd2,
      PH_SDATA  = 4'd3,
      PH_SCHK   = 4'd4,
      PH_SFIN   = 4'd5,
      PH_RSTART = 4'd6,
      PH_RLEN   = 4'd7,
      PH_RDATA  = 4'd8,
      PH_RCHK   = 4'd9,
      PH_WSTOP  = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_RESTART = 3'd2,
      ACT_STOP    = 3'd3,
      ACT_SEND    = 3'd4,
      ACT_CLOCK   = 3'd5,
      ACT_ACK     = 3'd6
   } act_type;

   typedef struct packed {
      act_type    bus_action;
      logic [7:0] send_byte;
      logic       rx_valid;
      logic [7:0] rx_position;
      logic [7:0] rx_data;
      logic       done_res;
      logic       check_error;
      logic [7:0] rx_total;
      logic       rejected;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [TX_AW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic [TX_AW-1:0] rd_addr;
   } store_ctl_type;

endpackage

// ===== rtl/i2c_fts_store.sv =====
// Transmit byte store: one write port, one registered read port.
// Depends on i2c_fts_pkg for the store depth and control struct.

module i2c_fts_store
   import i2c_fts_pkg::*;
(
   input  logic          clock,
   input  store_ctl_type ctl,
   output logic [7:0]    rd_data
);

   logic [7:0] tx_store_ff [TX_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         tx_store_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= tx_store_ff[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2c_fts_core.sv =====
// Transaction state and per-request update: phase, indices, checksum.
// Depends on i2c_fts_pkg; reads the store through its registered port.

module i2c_fts_core
   import i2c_fts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [1:0]    cmd,
   input  logic [7:0]    data_byte,
   input  logic [6:0]    slave_address,
   input  logic [6:0]    tx_count,
   input  logic [7:0]    rx_room,
   input  logic          arbitration_lost,
   input  logic          acked,
   input  logic [7:0]    store_data,
   output store_ctl_type store_ctl,
   output rsp_type       rsp
);

   phase_type         phase_ff, phase_in;
   logic              writing_ff, writing_in;
   logic [7:0]        byte_index_ff, byte_index_in;
   logic [7:0]        receive_limit_ff, receive_limit_in;
   logic [7:0]        running_sum_ff, running_sum_in;
   logic              need_clock_ff, need_clock_in;
   logic [6:0]        target_ff, target_in;
   logic [SEND_W-1:0] send_total_ff, send_total_in;
   logic [7:0]        read_room_ff, read_room_in;
   logic              mismatch_ff, mismatch_in;

   logic [7:0] addr_byte;
   logic [7:0] idx_inc;
   logic [7:0] send_total_ext;
   logic [7:0] limit_pick;
   logic       tx_clamp;

   assign addr_byte      = {target_ff, ~writing_ff};
   assign idx_inc        = byte_index_ff + 8'd1;
   assign send_total_ext = 8'(send_total_ff);
   assign limit_pick     = (data_byte < read_room_ff) ? data_byte : read_room_ff;
   assign tx_clamp       = ({1'b0, tx_count} > 8'(TX_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         writing_ff       <= 1'b0;
         byte_index_ff    <= '0;
         receive_limit_ff <= '0;
         running_sum_ff   <= '0;
         need_clock_ff    <= 1'b0;
         target_ff        <= '0;
         send_total_ff    <= '0;
         read_room_ff     <= '0;
         mismatch_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         writing_ff       <= writing_in;
         byte_index_ff    <= byte_index_in;
         receive_limit_ff <= receive_limit_in;
         running_sum_ff   <= running_sum_in;
         need_clock_ff    <= need_clock_in;
         target_ff        <= target_in;
         send_total_ff    <= send_total_in;
         read_room_ff     <= read_room_in;
         mismatch_ff      <= mismatch_in;
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      writing_in        = writing_ff;
      byte_index_in     = byte_index_ff;
      receive_limit_in  = receive_limit_ff;
      running_sum_in    = running_sum_ff;
      need_clock_in     = need_clock_ff;
      target_in         = target_ff;
      send_total_in     = send_total_ff;
      read_room_in      = read_room_ff;
      mismatch_in       = mismatch_ff;
      rsp               = '0;
      rsp.bus_action    = ACT_NONE;
      store_ctl.wr_en   = 1'b0;
      store_ctl.wr_addr = byte_index_ff[TX_AW-1:0];
      store_ctl.wr_data = data_byte;

      if (accept) begin
         case (cmd_type'(cmd))
            CMD_LOAD: begin
               if (phase_ff == PH_IDLE && byte_index_ff < 8'(TX_DEPTH)) begin
                  store_ctl.wr_en = 1'b1;
                  byte_index_in   = idx_inc;
               end
            end
            CMD_START: begin
               if (phase_ff != PH_IDLE || (tx_count == '0 && rx_room == '0)) begin
                  rsp.rejected = 1'b1;
               end else begin
                  target_in        = slave_address;
                  send_total_in    = tx_clamp ? SEND_W'(TX_DEPTH) : SEND_W'(tx_count);
                  read_room_in     = rx_room;
                  writing_in       = (tx_count != '0);
                  byte_index_in    = '0;
                  running_sum_in   = '0;
                  receive_limit_in = '0;
                  need_clock_in    = 1'b0;
                  mismatch_in      = 1'b0;
                  phase_in         = PH_ADDR;
                  rsp.bus_action   = ACT_START;
               end
            end
            CMD_EVENT: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (arbitration_lost) begin
                        rsp.bus_action = ACT_START;
                     end else begin
                        rsp.bus_action = ACT_SEND;
                        rsp.send_byte  = addr_byte;
                        byte_index_in  = '0;
                        running_sum_in = addr_byte;
                        phase_in       = writing_ff ? PH_SLEN : PH_RSTART;
                     end
                  end
                  PH_SLEN, PH_SDATA, PH_SCHK, PH_SFIN: begin
                     if (arbitration_lost) begin
                        rsp.bus_action = ACT_START;
                        phase_in       = PH_ADDR;
                     end else if (acked && phase_ff != PH_SFIN) begin
                        rsp.bus_action = ACT_SEND;
                        if (phase_ff == PH_SLEN) begin
                           rsp.send_byte  = send_total_ext;
                           running_sum_in = running_sum_ff + send_total_ext;
                           phase_in       = (send_total_ff != '0) ? PH_SDATA : PH_SCHK;
                        end else if (phase_ff == PH_SDATA) begin
                           rsp.send_byte  = store_data;
                           byte_index_in  = idx_inc;
                           running_sum_in = running_sum_ff + store_data;
                           if (idx_inc >= send_total_ext) begin
                              phase_in = PH_SCHK;
                           end
                        end else begin
                           rsp.send_byte = running_sum_ff;
                           phase_in      = PH_SFIN;
                        end
                     end else if (read_room_ff != '0) begin
                        // write phase over: turn the bus around for the read
                        rsp.bus_action = ACT_RESTART;
                        writing_in     = 1'b0;
                        phase_in       = PH_ADDR;
                     end else begin
                        rsp.bus_action = ACT_STOP;
                        phase_in       = PH_WSTOP;
                     end
                  end
                  PH_RSTART: begin
                     if (acked) begin
                        rsp.bus_action = ACT_CLOCK;
                        phase_in       = PH_RLEN;
                     end else begin
                        rsp.bus_action = ACT_STOP;
                        phase_in       = PH_WSTOP;
                     end
                  end
                  PH_RLEN: begin
                     receive_limit_in = limit_pick;
                     running_sum_in   = running_sum_ff + data_byte;
                     rsp.bus_action   = ACT_ACK;
                     need_clock_in    = 1'b1;
                     phase_in         = (limit_pick != '0) ? PH_RDATA : PH_RCHK;
                  end
                  PH_RDATA: begin
                     if (need_clock_ff) begin
                        rsp.bus_action = ACT_CLOCK;
                        need_clock_in  = 1'b0;
                     end else begin
                        rsp.bus_action  = ACT_ACK;
                        rsp.rx_valid    = 1'b1;
                        rsp.rx_position = byte_index_ff;
                        rsp.rx_data     = data_byte;
                        byte_index_in   = idx_inc;
                        running_sum_in  = running_sum_ff + data_byte;
                        need_clock_in   = 1'b1;
                        if (idx_inc >= receive_limit_ff) begin
                           phase_in = PH_RCHK;
                        end
                     end
                  end
                  PH_RCHK: begin
                     if (need_clock_ff) begin
                        rsp.bus_action = ACT_CLOCK;
                        need_clock_in  = 1'b0;
                     end else begin
                        mismatch_in    = (data_byte != running_sum_ff);
                        rsp.bus_action = ACT_STOP;
                        phase_in       = PH_WSTOP;
                     end
                  end
                  PH_WSTOP: begin
                     rsp.done_res    = 1'b1;
                     rsp.check_error = mismatch_ff;
                     rsp.rx_total    = writing_ff ? 8'd0 : byte_index_ff;
                     byte_index_in   = '0;
                     phase_in        = PH_IDLE;
                  end
                  default: begin
                     // idle: drop the event
                  end
               endcase
            end
            default: begin
               // unused command code: no action
            end
         endcase
      end

      // prefetch the entry the next request may send
      store_ctl.rd_addr = byte_index_in[TX_AW-1:0];
   end

   a_leave_idle_to_addr: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE && phase_in != PH_IDLE) |-> phase_in == PH_ADDR)
      else $error("idle left for a phase other than address");

   a_need_clock_in_read: assert property (@(posedge clock) disable iff (reset)
      need_clock_ff |-> (phase_ff == PH_RDATA || phase_ff == PH_RCHK))
      else $error("clock request pending outside read data/check");

   a_store_write_idle: assert property (@(posedge clock) disable iff (reset)
      store_ctl.wr_en |-> (phase_ff == PH_IDLE && byte_index_ff < 8'(TX_DEPTH)))
      else $error("store written while busy or full");

   a_send_index_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SDATA |-> byte_index_ff < send_total_ext)
      else $error("send index past transmit count");

   a_prefetch_follows: assert property (@(posedge clock) disable iff (reset)
      !accept |=> byte_index_ff == $past(byte_index_ff))
      else $error("byte index moved without a request");

endmodule

// ===== rtl/i2c_framed_transfer_sequencer.sv =====
// Top level of the I2C framed transfer sequencer: handshake and result register.
// Depends on i2c_fts_pkg, i2c_fts_store and i2c_fts_core.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | cmd, data, address, counts, bus event
//   rsp     | out       | rsp_valid/rsp_stall | one bus action and status per request
//
// Every request gives exactly one response, in the cycle after it is accepted.
// A request can be accepted every cycle; the only limit is the response register:
// req_stall is high while a response waits and rsp_stall holds it.
// Reset (synchronous) returns to idle with an empty transmit store count.
// The transmit store is read through a registered port, prefetched at the next index.

module i2c_framed_transfer_sequencer
   import i2c_fts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic [6:0] req_slave_address,
   input  logic [6:0] req_tx_count,
   input  logic [7:0] req_rx_room,
   input  logic       req_arbitration_lost,
   input  logic       req_acked,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_bus_action,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_position,
   output logic [7:0] rsp_rx_data,
   output logic       rsp_done_res,
   output logic       rsp_check_error,
   output logic [7:0] rsp_rx_total,
   output logic       rsp_rejected
);

   logic          accept;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       core_rsp;
   store_ctl_type store_ctl;
   logic [7:0]    store_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   i2c_fts_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_data (store_data)
   );

   i2c_fts_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .cmd              (req_cmd),
      .data_byte        (req_data_byte),
      .slave_address    (req_slave_address),
      .tx_count         (req_tx_count),
      .rx_room          (req_rx_room),
      .arbitration_lost (req_arbitration_lost),
      .acked            (req_acked),
      .store_data       (store_data),
      .store_ctl        (store_ctl),
      .rsp              (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response payload until the next request replaces it
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bus_action  = rsp_ff.bus_action;
   assign rsp_send_byte   = rsp_ff.send_byte;
   assign rsp_rx_valid    = rsp_ff.rx_valid;
   assign rsp_rx_position = rsp_ff.rx_position;
   assign rsp_rx_data     = rsp_ff.rx_data;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_check_error = rsp_ff.check_error;
   assign rsp_rx_total    = rsp_ff.rx_total;
   assign rsp_rejected    = rsp_ff.rejected;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for i2c_framed_transfer_sequencer: directed and random requests, each response
// checked in order against a behavioral predictor of the bus sequence and framing sum.
// Depends on i2c_fts_pkg and the sequencer RTL.

module tb_top;
   import i2c_fts_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 2000;
   localparam int TAIL_CYCLES  = 4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
      logic [6:0] addr;
      logic [6:0] txc;
      logic [7:0] room;
      logic       arb;
      logic       ack;
   } xfer_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_data_byte = '0;
   logic [6:0] req_slave_address = '0;
   logic [6:0] req_tx_count = '0;
   logic [7:0] req_rx_room = '0;
   logic       req_arbitration_lost = 1'b0;
   logic       req_acked = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_bus_action;
   logic [7:0] rsp_send_byte;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_position;
   logic [7:0] rsp_rx_data;
   logic       rsp_done_res;
   logic       rsp_check_error;
   logic [7:0] rsp_rx_total;
   logic       rsp_rejected;

   // predicted sequencer state
   phase_type  seq_phase;
   logic       seq_writing;
   logic [7:0] seq_index;
   logic [7:0] seq_limit;
   logic [7:0] seq_sum;
   logic       seq_need_clock;
   logic [6:0] seq_target;
   logic [6:0] seq_send_total;
   logic [7:0] seq_read_room;
   logic       seq_mismatch;
   logic [7:0] tx_bytes [TX_DEPTH];
   logic       took_effect;

   rsp_type awaited_actions [$];
   int      errors = 0;
   int      req_idle_pct = 20;
   int      rsp_idle_pct = 20;
   int      hold_asked = 0;

   always #4 clock = ~clock;

   i2c_framed_transfer_sequencer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_cmd              (req_cmd),
      .req_data_byte        (req_data_byte),
      .req_slave_address    (req_slave_address),
      .req_tx_count         (req_tx_count),
      .req_rx_room          (req_rx_room),
      .req_arbitration_lost (req_arbitration_lost),
      .req_acked            (req_acked),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_bus_action       (rsp_bus_action),
      .rsp_send_byte        (rsp_send_byte),
      .rsp_rx_valid         (rsp_rx_valid),
      .rsp_rx_position      (rsp_rx_position),
      .rsp_rx_data          (rsp_rx_data),
      .rsp_done_res         (rsp_done_res),
      .rsp_check_error      (rsp_check_error),
      .rsp_rx_total         (rsp_rx_total),
      .rsp_rejected         (rsp_rejected)
   );

   // Advance the predicted state by one request and return the bus action it causes.
   function automatic rsp_type predict_bus_step(xfer_req_type r);
      rsp_type    o;
      logic [7:0] b;
      o = '0;
      took_effect = 1'b1;
      case (r.cmd)
         CMD_LOAD: begin
            if (seq_phase == PH_IDLE && seq_index < TX_DEPTH) begin
               tx_bytes[seq_index[TX_AW-1:0]] = r.data;
               seq_index = seq_index + 8'd1;
            end else begin
               took_effect = 1'b0;
            end
         end
         CMD_START: begin
            if (seq_phase != PH_IDLE || (r.txc == 0 && r.room == 0)) begin
               o.rejected = 1'b1;
            end else begin
               seq_target = r.addr;
               seq_send_total = (r.txc > TX_DEPTH) ? 7'(TX_DEPTH) : r.txc;
               seq_read_room = r.room;
               seq_writing = (r.txc != 0);
               seq_index = '0;
               seq_sum = '0;
               seq_limit = '0;
               seq_need_clock = 1'b0;
               seq_mismatch = 1'b0;
               seq_phase = PH_ADDR;
               o.bus_action = ACT_START;
            end
         end
         CMD_EVENT: begin
            case (seq_phase)
               PH_ADDR: begin
                  if (r.arb) begin
                     o.bus_action = ACT_START;
                  end else begin
                     b = {seq_target, ~seq_writing};
                     o.bus_action = ACT_SEND;
                     o.send_byte = b;
                     seq_index = '0;
                     seq_sum = b;
                     seq_phase = seq_writing ? PH_SLEN : PH_RSTART;
                  end
               end
               PH_SLEN, PH_SDATA, PH_SCHK, PH_SFIN: begin
                  if (r.arb) begin
                     o.bus_action = ACT_START;
                     seq_phase = PH_ADDR;
                  end else if (r.ack && seq_phase != PH_SFIN) begin
                     case (seq_phase)
                        PH_SLEN: begin
                           b = {1'b0, seq_send_total};
                           seq_sum = seq_sum + b;
                           seq_phase = (seq_send_total != 0) ? PH_SDATA : PH_SCHK;
                        end
                        PH_SDATA: begin
                           b = tx_bytes[seq_index[TX_AW-1:0]];
                           seq_index = seq_index + 8'd1;
                           seq_sum = seq_sum + b;
                           if (seq_index >= seq_send_total) seq_phase = PH_SCHK;
                        end
                        default: begin
                           b = seq_sum;
                           seq_phase = PH_SFIN;
                        end
                     endcase
                     o.bus_action = ACT_SEND;
                     o.send_byte = b;
                  end else if (seq_read_room != 0) begin
                     o.bus_action = ACT_RESTART;
                     seq_writing = 1'b0;
                     seq_phase = PH_ADDR;
                  end else begin
                     o.bus_action = ACT_STOP;
                     seq_phase = PH_WSTOP;
                  end
               end
               PH_RSTART: begin
                  if (r.ack) begin
                     o.bus_action = ACT_CLOCK;
                     seq_phase = PH_RLEN;
                  end else begin
                     o.bus_action = ACT_STOP;
                     seq_phase = PH_WSTOP;
                  end
               end
               PH_RLEN: begin
                  // clip the slave's length to the room given at start
                  seq_limit = (r.data < seq_read_room) ? r.data : seq_read_room;
                  seq_sum = seq_sum + r.data;
                  o.bus_action = ACT_ACK;
                  seq_need_clock = 1'b1;
                  seq_phase = (seq_limit != 0) ? PH_RDATA : PH_RCHK;
               end
               PH_RDATA: begin
                  if (seq_need_clock) begin
                     o.bus_action = ACT_CLOCK;
                     seq_need_clock = 1'b0;
                  end else begin
                     o.bus_action = ACT_ACK;
                     o.rx_valid = 1'b1;
                     o.rx_position = seq_index;
                     o.rx_data = r.data;
                     seq_index = seq_index + 8'd1;
                     seq_sum = seq_sum + r.data;
                     seq_need_clock = 1'b1;
                     if (seq_index >= seq_limit) seq_phase = PH_RCHK;
                  end
               end
               PH_RCHK: begin
                  if (seq_need_clock) begin
                     o.bus_action = ACT_CLOCK;
                     seq_need_clock = 1'b0;
                  end else begin
                     seq_mismatch = (r.data != seq_sum);
                     o.bus_action = ACT_STOP;
                     seq_phase = PH_WSTOP;
                  end
               end
               PH_WSTOP: begin
                  o.done_res = 1'b1;
                  o.check_error = seq_mismatch;
                  o.rx_total = seq_writing ? 8'd0 : seq_index;
                  seq_index = '0;
                  seq_phase = PH_IDLE;
               end
               default: took_effect = 1'b0;
            endcase
         end
         default: took_effect = 1'b0;
      endcase
      return o;
   endfunction

   // Pick a request that moves the current transaction along, with random content.
   function automatic xfer_req_type next_bus_item();
      xfer_req_type r;
      int           pick;
      r = 34'({$urandom(), $urandom()});
      r.cmd = CMD_EVENT;
      case (seq_phase)
         PH_IDLE: begin
            if ($urandom_range(99) < 30) begin
               r.cmd = CMD_LOAD;
            end else begin
               r.cmd = CMD_START;
               pick = $urandom_range(99);
               r.txc = (pick < 70) ? 7'($urandom_range(6)) :
                       (pick < 90) ? 7'($urandom_range(64, 7)) : 7'($urandom_range(127, 65));
               pick = $urandom_range(99);
               r.room = (pick < 45) ? 8'd0 :
                        (pick < 85) ? 8'($urandom_range(8, 1)) : 8'($urandom);
               if (r.txc == 0 && r.room == 0) r.room = 8'd1;
            end
         end
         PH_ADDR: r.arb = ($urandom_range(99) < 10);
         PH_SLEN, PH_SDATA, PH_SCHK: begin
            r.arb = ($urandom_range(99) < 4);
            r.ack = ($urandom_range(99) < 92);
         end
         PH_SFIN: r.arb = ($urandom_range(99) < 5);
         PH_RSTART: r.ack = ($urandom_range(99) < 90);
         PH_RLEN: if ($urandom_range(99) < 85) r.data = 8'($urandom_range(10));
         PH_RCHK: if (!seq_need_clock && $urandom_range(99) < 75) r.data = seq_sum;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_request(xfer_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_data_byte <= r.data;
      req_slave_address <= r.addr;
      req_tx_count <= r.txc;
      req_rx_room <= r.room;
      req_arbitration_lost <= r.arb;
      req_acked <= r.ack;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_actions.push_back(predict_bus_step(r));
   endtask

   task automatic send_load(logic [7:0] d);
      xfer_req_type r;
      r = '0;
      r.cmd = CMD_LOAD;
      r.data = d;
      send_request(r);
   endtask

   task automatic send_start(logic [6:0] addr, logic [6:0] txc, logic [7:0] room);
      xfer_req_type r;
      r = '0;
      r.cmd = CMD_START;
      r.addr = addr;
      r.txc = txc;
      r.room = room;
      send_request(r);
   endtask

   task automatic send_bus_event(logic [7:0] d, logic arb, logic ack);
      xfer_req_type r;
      r = '0;
      r.cmd = CMD_EVENT;
      r.data = d;
      r.arb = arb;
      r.ack = ack;
      send_request(r);
   endtask

   task automatic drain_responses(int max_cycles);
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (awaited_actions.size() != 0 && n < max_cycles) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic test_idle_requests();
      send_bus_event(8'hFF, 1'b1, 1'b1);   // nothing in flight: no action
      send_request('1);                    // unused command code
      send_start(7'h55, 7'd0, 8'd0);       // nothing to send or receive
   endtask

   task automatic test_write_then_read();
      int k;
      send_load(8'h00);
      send_load(8'hFF);
      send_start(7'h7F, 7'd2, 8'd3);
      send_start(7'h01, 7'd1, 8'd1);       // busy: refused
      send_load(8'h3C);                    // busy: dropped
      repeat (5) send_bus_event(8'h00, 1'b0, 1'b1);   // address, length, two data, check
      send_bus_event(8'h00, 1'b0, 1'b1);   // check sent: repeated start
      send_bus_event(8'h00, 1'b0, 1'b0);   // read address
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'd5, 1'b0, 1'b0);    // slave offers more than the room
      for (k = 0; k < 3; k++) begin
         send_bus_event(8'h00, 1'b0, 1'b0);
         send_bus_event(8'($urandom), 1'b1, 1'b0);   // arbitration is ignored while reading
      end
      send_bus_event(8'h00, 1'b0, 1'b0);
      send_bus_event(seq_sum, 1'b0, 1'b0);
      send_bus_event(8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_read_only_and_arbitration();
      send_start(7'h2A, 7'd0, 8'd255);
      send_bus_event(8'h00, 1'b1, 1'b1);   // lost arbitration on the address
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'h00, 1'b0, 1'b0);   // read address not acked: stop
      send_bus_event(8'h00, 1'b0, 1'b0);
      send_start(7'h00, 7'd1, 8'd2);
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'h00, 1'b1, 1'b1);   // lost during length: back to address
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'h00, 1'b0, 1'b0);   // length not acked: go read
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'h00, 1'b0, 1'b1);
      send_bus_event(8'h00, 1'b0, 1'b0);   // zero length: straight to check
      send_bus_event(8'h00, 1'b0, 1'b0);
      send_bus_event(~seq_sum, 1'b0, 1'b0);
      send_bus_event(8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_random_traffic(int count);
      xfer_req_type r;
      int           sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) r = next_bus_item();
         else r = 34'({$urandom(), $urandom()});
         send_request(r);
         if (took_effect) sent++;
      end
   endtask

   task automatic test_full_store();
      int k;
      // one load past the end finds the store full
      for (k = 0; k <= TX_DEPTH; k++) send_load(8'($urandom));
      send_start(7'($urandom), 7'($urandom_range(127, 65)), 8'($urandom_range(3)));
      while (seq_phase != PH_IDLE) send_request(next_bus_item());
   endtask

   task automatic test_no_idle_stretch();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(200);
      req_idle_pct = 20;
      rsp_idle_pct = 20;
   endtask

   task automatic test_response_hold();
      req_idle_pct = 0;
      hold_asked = hold_asked + 1;
      test_random_traffic(60);
      drain_responses(DRAIN_CYCLES);
      req_idle_pct = 20;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_actions.size() == 0) begin
            $display("%0t: response with none pending, bus_action %0d", $time, rsp_bus_action);
            errors++;
         end else begin
            want = awaited_actions.pop_front();
            check_field("bus_action", want.bus_action, rsp_bus_action);
            check_field("send_byte", want.send_byte, rsp_send_byte);
            check_field("rx_valid", want.rx_valid, rsp_rx_valid);
            check_field("rx_position", want.rx_position, rsp_rx_position);
            check_field("rx_data", want.rx_data, rsp_rx_data);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("check_error", want.check_error, rsp_check_error);
            check_field("rx_total", want.rx_total, rsp_rx_total);
            check_field("rejected", want.rejected, rsp_rejected);
         end
      end
   end

   initial begin : rsp_side
      int served;
      int k;
      served = 0;
      forever begin
         @(posedge clock);
         if (served != hold_asked) begin
            served++;
            for (k = 0; k < HOLD_CYCLES; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      seq_phase = PH_IDLE;
      seq_writing = 1'b0;
      seq_index = '0;
      seq_limit = '0;
      seq_sum = '0;
      seq_need_clock = 1'b0;
      seq_target = '0;
      seq_send_total = '0;
      seq_read_room = '0;
      seq_mismatch = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_write_then_read();
      test_read_only_and_arbitration();
      test_full_store();
      test_random_traffic(400);
      test_no_idle_stretch();
      test_response_hold();
      test_random_traffic(240);

      drain_responses(DRAIN_CYCLES);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_actions.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, awaited_actions.size());
         errors++;
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
